// File: design/plm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the price level order matcher.
// No dependencies; imported by price_level_order_matcher and tb_top.
package plm_pkg;

	// Default sizing of the price window and the fill tape ring
	localparam int unsigned DEF_WINDOW_TICKS = 1024;
	localparam int unsigned DEF_TAPE_DEPTH   = 16;

	// Operation and side codes
	localparam logic OP_ORDER = 1'b0;
	localparam logic OP_TAPE  = 1'b1;
	localparam logic SIDE_BID = 1'b0;
	localparam logic SIDE_ASK = 1'b1;

	// Saturation value of the per-order fill counter
	localparam logic [10:0] SWEPT_MAX = 11'h7FF;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_INIT,   // clearing pass over both level memories after reset
		ST_IDLE,   // waiting for a word
		ST_MREAD,  // match scan: read opposite level
		ST_MEVAL,  // match scan: evaluate level, fill and write back
		ST_REST,   // write remainder at own tick
		ST_SREAD,  // best scan: read both sides
		ST_SEVAL,  // best scan: evaluate both sides
		ST_CTR,    // recentre check, compute mid
		ST_DLT,    // compute shift and clear run
		ST_CLEAR,  // zero levels that left the window
		ST_TREAD,  // fill tape read
		ST_DONE    // hand result to output register
	} plm_state_t;

endpackage

// File: design/price_level_order_matcher.sv
`timescale 1ns / 1ps
// Price level order matcher: bid/ask level memories over a sliding window,
// matching sequencer, recentring and a fill tape ring. Depends on plm_pkg.
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+--------------------------------------------
//  input    | in_valid / in_ready  | op side limit_tick quantity timestamp tape_index
//  output   | out_valid / out_ready| top_*, filled_total .. remainder_lost, tape_*
//
// Reset runs a clearing pass over every address of both level memories before
// the first word is taken. A word is taken only in the idle state. An order then
// takes a read and an evaluate state per level of the match scan, the rest state,
// a read and an evaluate state per step of the best scan (at most WINDOW_TICKS
// steps) and the recentre check up to the result load; a recentre adds the shift
// state, a clear run over |shift| addresses and, for a nonzero shift, a second
// best scan. The single read port of each level memory sets this sequence. A tape
// read passes through the tape read state. One word is in work at a time; the
// output register lets the next word in while a result waits for out_ready.
module price_level_order_matcher #(
	parameter int unsigned WINDOW_TICKS = plm_pkg::DEF_WINDOW_TICKS,
	parameter int unsigned TAPE_DEPTH   = plm_pkg::DEF_TAPE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic        side,
	input  logic [31:0] limit_tick,
	input  logic [31:0] quantity,
	input  logic [63:0] timestamp,
	input  logic [3:0]  tape_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] top_bid,
	output logic        top_bid_valid,
	output logic [31:0] top_ask,
	output logic        top_ask_valid,
	output logic [31:0] filled_total,
	output logic [10:0] levels_swept,
	output logic [31:0] rested_qty,
	output logic        remainder_lost,
	output logic [31:0] tape_tick,
	output logic [31:0] tape_qty,
	output logic [63:0] tape_time,
	output logic        tape_valid
);
	import plm_pkg::*;

	localparam int AW = $clog2(WINDOW_TICKS);
	localparam int TW = $clog2(TAPE_DEPTH);
	localparam int CW = TW + 1;
	localparam int KW = ((TW > 4) ? TW : 4) + 1;
	localparam logic [AW-1:0] OFF_LAST = AW'(WINDOW_TICKS - 1);
	localparam logic [AW-1:0] OFF_HALF = AW'(WINDOW_TICKS / 2);
	localparam logic [AW-1:0] OFF_QTR  = AW'(WINDOW_TICKS / 4);
	localparam logic [AW-1:0] OFF_OUT  = AW'(WINDOW_TICKS - WINDOW_TICKS / 4);

	// Offset within the window to physical memory address (ring of WINDOW_TICKS)
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] o, input logic [AW-1:0] b);
		logic [AW:0] s;
		s = {1'b0, o} + {1'b0, b};
		if (s >= (AW+1)'(WINDOW_TICKS))
			s = s - (AW+1)'(WINDOW_TICKS);
		return s[AW-1:0];
	endfunction

	function automatic logic outer(input logic [AW-1:0] o);
		return (o < OFF_QTR) || (o >= OFF_OUT);
	endfunction

	// Level memories
	logic [31:0] bid_mem [WINDOW_TICKS];
	logic [31:0] ask_mem [WINDOW_TICKS];
	logic [31:0] bid_rd_q, ask_rd_q;
	logic [AW-1:0] bid_ra, ask_ra, bid_wa, ask_wa;
	logic [31:0] bid_wd, ask_wd;
	logic bid_we, ask_we;

	// Fill tape ring
	logic [31:0] tp_price_mem [TAPE_DEPTH];
	logic [31:0] tp_amt_mem   [TAPE_DEPTH];
	logic [63:0] tp_stamp_mem [TAPE_DEPTH];
	logic [31:0] t_price_q, t_amt_q;
	logic [63:0] t_stamp_q;
	logic [TW-1:0] head_q, trd_addr_q;
	logic [CW-1:0] tcnt_q;
	logic tvalid_q;

	// Control and working registers
	plm_state_t state_q, state_d;
	logic op_q, side_q;
	logic [31:0] price_q, rem_q, filled_q, rested_q;
	logic [63:0] stamp_q;
	logic [10:0] swept_q;
	logic lost_q;
	logic [31:0] origin_q;
	logic wset_q;
	logic [AW-1:0] base_q, off_q, addr_q;
	logic [AW-1:0] bid_off_q, ask_off_q, bo_q, ao_q;
	logic bid_scan_q, ask_scan_q, bv_q, av_q, pass2_q;
	logic [AW-1:0] moff_q, nbase_q, clr_addr_q;
	logic [AW:0] clr_cnt_q;
	logic [32:0] mid_q;

	// Output register
	logic out_valid_q;
	logic [31:0] o_bid_q, o_ask_q, o_filled_q, o_rested_q, o_tick_q, o_qty_q;
	logic [63:0] o_time_q;
	logic [10:0] o_swept_q;
	logic o_bv_q, o_av_q, o_lost_q, o_tvalid_q;

	// Match datapath
	logic [31:0] opp_rd, take, rem_after;
	logic [32:0] tick33, rel33;
	logic beyond, fill, at_end, in_win;
	logic [AW-1:0] match_pa, rest_pa;

	assign opp_rd    = (side_q == SIDE_ASK) ? bid_rd_q : ask_rd_q;
	assign tick33    = {1'b0, origin_q} + 33'(off_q);
	assign beyond    = (side_q == SIDE_BID) ? (tick33 > {1'b0, price_q})
	                                        : (tick33 < {1'b0, price_q});
	assign take      = (rem_q < opp_rd) ? rem_q : opp_rd;
	assign rem_after = rem_q - take;
	assign fill      = (state_q == ST_MEVAL) && (opp_rd != 32'd0) && !beyond;
	assign at_end    = (side_q == SIDE_BID) ? (off_q == OFF_LAST) : (off_q == '0);
	assign match_pa  = phys(off_q, base_q);
	assign rel33     = {1'b0, price_q} - {1'b0, origin_q};
	assign in_win    = (price_q >= origin_q) && (rel33 < 33'(WINDOW_TICKS));
	assign rest_pa   = phys(rel33[AW-1:0], base_q);

	// Best scan finish conditions
	logic bid_fin, ask_fin;
	assign bid_fin = !bid_scan_q || (bid_rd_q != 32'd0) || (bid_off_q == '0);
	assign ask_fin = !ask_scan_q || (ask_rd_q != 32'd0) || (ask_off_q == OFF_LAST);

	// Recentre arithmetic
	logic need_rc;
	logic [AW-1:0] moff_c;
	logic [AW:0] pair_sum;
	assign need_rc  = (bv_q && outer(bo_q)) || (av_q && outer(ao_q));
	assign pair_sum = {1'b0, bo_q} + {1'b0, ao_q};
	assign moff_c   = (bv_q && av_q) ? pair_sum[AW:1] : (bv_q ? bo_q : ao_q);

	logic ge, dpos;
	logic [AW-1:0] dmag, nbase_c, start_c;
	logic [AW:0] wrap_off;
	logic [32:0] nb33;
	always_comb begin
		ge   = mid_q >= 33'(WINDOW_TICKS / 2);
		nb33 = mid_q - 33'(WINDOW_TICKS / 2);
		if (ge && (moff_q >= OFF_HALF)) begin
			dpos = 1'b1;
			dmag = moff_q - OFF_HALF;
		end else if (ge) begin
			dpos = 1'b0;
			dmag = OFF_HALF - moff_q;
		end else begin
			dpos = 1'b0;
			dmag = origin_q[AW-1:0];
		end
		wrap_off = (AW+1)'(WINDOW_TICKS) - {1'b0, dmag};
		nbase_c  = dpos ? phys(dmag, base_q) : phys(wrap_off[AW-1:0], base_q);
		start_c  = dpos ? base_q : nbase_c;
	end

	// Tape read address
	logic [KW-1:0] tk_sum;
	logic [TW-1:0] tk_addr;
	always_comb begin
		tk_sum = KW'(head_q) + KW'(TAPE_DEPTH - 1) - KW'(tape_index);
		if (tk_sum >= KW'(TAPE_DEPTH))
			tk_sum = tk_sum - KW'(TAPE_DEPTH);
		tk_addr = tk_sum[TW-1:0];
	end

	logic accept, out_load, tape_we;
	logic [AW-1:0] clr_next;
	assign accept   = in_valid && in_ready;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign tape_we  = fill;
	assign clr_next = (clr_addr_q == OFF_LAST) ? '0 : clr_addr_q + 1'b1;
	assign in_ready = (state_q == ST_IDLE);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT:  if (clr_addr_q == OFF_LAST) state_d = ST_IDLE;
			ST_IDLE: begin
				if (in_valid) begin
					if (op == OP_TAPE)
						state_d = ST_TREAD;
					else if (quantity != 32'd0 && ((side == SIDE_ASK) ? bv_q : av_q))
						state_d = ST_MREAD;
					else
						state_d = ST_REST;
				end
			end
			ST_MREAD: state_d = ST_MEVAL;
			ST_MEVAL: begin
				if (opp_rd == 32'd0)
					state_d = at_end ? ST_REST : ST_MREAD;
				else if (beyond || rem_after == 32'd0 || at_end)
					state_d = ST_REST;
				else
					state_d = ST_MREAD;
			end
			ST_REST:  state_d = ST_SREAD;
			ST_SREAD: state_d = ST_SEVAL;
			ST_SEVAL: begin
				if (bid_fin && ask_fin)
					state_d = pass2_q ? ST_DONE : ST_CTR;
				else
					state_d = ST_SREAD;
			end
			ST_CTR:   state_d = need_rc ? ST_DLT : ST_DONE;
			ST_DLT:   state_d = (dmag == '0) ? ST_DONE : ST_CLEAR;
			ST_CLEAR: if (clr_cnt_q == (AW+1)'(1)) state_d = ST_SREAD;
			ST_TREAD: state_d = ST_DONE;
			ST_DONE:  if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Memory port control
	always_comb begin
		bid_we = 1'b0;
		ask_we = 1'b0;
		bid_wa = clr_addr_q;
		ask_wa = clr_addr_q;
		bid_wd = 32'd0;
		ask_wd = 32'd0;
		bid_ra = phys(bid_off_q, base_q);
		ask_ra = phys(ask_off_q, base_q);
		unique case (state_q)
			ST_INIT, ST_CLEAR: begin
				bid_we = 1'b1;
				ask_we = 1'b1;
			end
			ST_MREAD: begin
				if (side_q == SIDE_ASK)
					bid_ra = match_pa;
				else
					ask_ra = match_pa;
			end
			ST_MEVAL: begin
				if (fill) begin
					if (side_q == SIDE_ASK) begin
						bid_we = 1'b1;
						bid_wa = addr_q;
						bid_wd = opp_rd - take;
					end else begin
						ask_we = 1'b1;
						ask_wa = addr_q;
						ask_wd = opp_rd - take;
					end
				end
			end
			ST_REST: begin
				if (rem_q != 32'd0 && in_win) begin
					if (side_q == SIDE_BID) begin
						bid_we = 1'b1;
						bid_wa = rest_pa;
						bid_wd = rem_q;
					end else begin
						ask_we = 1'b1;
						ask_wa = rest_pa;
						ask_wd = rem_q;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Level memories: one write, one registered read each
	always_ff @(posedge clk) begin
		if (bid_we)
			bid_mem[bid_wa] <= bid_wd;
		if (ask_we)
			ask_mem[ask_wa] <= ask_wd;
		bid_rd_q <= bid_mem[bid_ra];
		ask_rd_q <= ask_mem[ask_ra];
	end

	// Fill tape ring
	always_ff @(posedge clk) begin
		if (tape_we) begin
			tp_price_mem[head_q] <= tick33[31:0];
			tp_amt_mem[head_q]   <= take;
			tp_stamp_mem[head_q] <= stamp_q;
		end
		if (state_q == ST_TREAD) begin
			t_price_q <= tp_price_mem[trd_addr_q];
			t_amt_q   <= tp_amt_mem[trd_addr_q];
			t_stamp_q <= tp_stamp_mem[trd_addr_q];
		end
	end

	// Sequencer datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			op_q       <= OP_ORDER;
			side_q     <= SIDE_BID;
			price_q    <= '0;
			rem_q      <= '0;
			stamp_q    <= '0;
			filled_q   <= '0;
			swept_q    <= '0;
			rested_q   <= '0;
			lost_q     <= 1'b0;
			origin_q   <= '0;
			wset_q     <= 1'b0;
			base_q     <= '0;
			off_q      <= '0;
			addr_q     <= '0;
			bid_off_q  <= '0;
			ask_off_q  <= '0;
			bo_q       <= '0;
			ao_q       <= '0;
			bid_scan_q <= 1'b0;
			ask_scan_q <= 1'b0;
			bv_q       <= 1'b0;
			av_q       <= 1'b0;
			pass2_q    <= 1'b0;
			moff_q     <= '0;
			mid_q      <= '0;
			nbase_q    <= '0;
			clr_addr_q <= '0;
			clr_cnt_q  <= '0;
			head_q     <= '0;
			tcnt_q     <= '0;
			trd_addr_q <= '0;
			tvalid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			// Tape pointers advance on every fill
			if (tape_we) begin
				head_q <= (head_q == TW'(TAPE_DEPTH - 1)) ? '0 : head_q + 1'b1;
				if (tcnt_q != CW'(TAPE_DEPTH))
					tcnt_q <= tcnt_q + 1'b1;
			end
			case (state_q)
				ST_INIT: clr_addr_q <= clr_next;
				ST_IDLE: begin
					if (accept) begin
						op_q     <= op;
						side_q   <= side;
						price_q  <= limit_tick;
						rem_q    <= quantity;
						stamp_q  <= timestamp;
						filled_q <= '0;
						swept_q  <= '0;
						rested_q <= '0;
						lost_q   <= 1'b0;
						pass2_q  <= 1'b0;
						off_q    <= (side == SIDE_ASK) ? bo_q : ao_q;
						// First order centres the window
						if (op == OP_ORDER && !wset_q) begin
							origin_q <= (limit_tick >= 32'(WINDOW_TICKS / 2))
							            ? limit_tick - 32'(WINDOW_TICKS / 2) : 32'd0;
							wset_q   <= 1'b1;
						end
						tvalid_q   <= KW'(tape_index) < KW'(tcnt_q);
						trd_addr_q <= tk_addr;
					end
				end
				ST_MREAD: addr_q <= match_pa;
				ST_MEVAL: begin
					if (fill) begin
						rem_q    <= rem_after;
						filled_q <= filled_q + take;
						if (swept_q != SWEPT_MAX)
							swept_q <= swept_q + 1'b1;
					end
					if ((opp_rd == 32'd0 || fill) && !at_end)
						off_q <= (side_q == SIDE_BID) ? off_q + 1'b1 : off_q - 1'b1;
				end
				ST_REST: begin
					if (rem_q != 32'd0) begin
						if (in_win)
							rested_q <= rem_q;
						else
							lost_q <= 1'b1;
					end
					bid_off_q  <= OFF_LAST;
					ask_off_q  <= '0;
					bid_scan_q <= 1'b1;
					ask_scan_q <= 1'b1;
					bv_q       <= 1'b0;
					av_q       <= 1'b0;
				end
				ST_SEVAL: begin
					if (bid_scan_q) begin
						if (bid_rd_q != 32'd0) begin
							bv_q       <= 1'b1;
							bo_q       <= bid_off_q;
							bid_scan_q <= 1'b0;
						end else if (bid_off_q == '0)
							bid_scan_q <= 1'b0;
						else
							bid_off_q <= bid_off_q - 1'b1;
					end
					if (ask_scan_q) begin
						if (ask_rd_q != 32'd0) begin
							av_q       <= 1'b1;
							ao_q       <= ask_off_q;
							ask_scan_q <= 1'b0;
						end else if (ask_off_q == OFF_LAST)
							ask_scan_q <= 1'b0;
						else
							ask_off_q <= ask_off_q + 1'b1;
					end
				end
				ST_CTR: begin
					moff_q <= moff_c;
					mid_q  <= {1'b0, origin_q} + 33'(moff_c);
				end
				ST_DLT: begin
					origin_q   <= ge ? nb33[31:0] : 32'd0;
					nbase_q    <= nbase_c;
					clr_addr_q <= start_c;
					clr_cnt_q  <= {1'b0, dmag};
					pass2_q    <= 1'b1;
				end
				ST_CLEAR: begin
					clr_addr_q <= clr_next;
					clr_cnt_q  <= clr_cnt_q - 1'b1;
					if (clr_cnt_q == (AW+1)'(1)) begin
						base_q     <= nbase_q;
						bid_off_q  <= OFF_LAST;
						ask_off_q  <= '0;
						bid_scan_q <= 1'b1;
						ask_scan_q <= 1'b1;
						bv_q       <= 1'b0;
						av_q       <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			o_bid_q     <= '0;
			o_ask_q     <= '0;
			o_bv_q      <= 1'b0;
			o_av_q      <= 1'b0;
			o_filled_q  <= '0;
			o_swept_q   <= '0;
			o_rested_q  <= '0;
			o_lost_q    <= 1'b0;
			o_tick_q    <= '0;
			o_qty_q     <= '0;
			o_time_q    <= '0;
			o_tvalid_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
				o_bid_q     <= bv_q ? origin_q + 32'(bo_q) : 32'd0;
				o_ask_q     <= av_q ? origin_q + 32'(ao_q) : 32'd0;
				o_bv_q      <= bv_q;
				o_av_q      <= av_q;
				o_filled_q  <= filled_q;
				o_swept_q   <= swept_q;
				o_rested_q  <= rested_q;
				o_lost_q    <= lost_q;
				o_tvalid_q  <= (op_q == OP_TAPE) && tvalid_q;
				o_tick_q    <= ((op_q == OP_TAPE) && tvalid_q) ? t_price_q : 32'd0;
				o_qty_q     <= ((op_q == OP_TAPE) && tvalid_q) ? t_amt_q : 32'd0;
				o_time_q    <= ((op_q == OP_TAPE) && tvalid_q) ? t_stamp_q : 64'd0;
			end else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid      = out_valid_q;
	assign top_bid        = o_bid_q;
	assign top_bid_valid  = o_bv_q;
	assign top_ask        = o_ask_q;
	assign top_ask_valid  = o_av_q;
	assign filled_total   = o_filled_q;
	assign levels_swept   = o_swept_q;
	assign rested_qty     = o_rested_q;
	assign remainder_lost = o_lost_q;
	assign tape_tick      = o_tick_q;
	assign tape_qty       = o_qty_q;
	assign tape_time      = o_time_q;
	assign tape_valid     = o_tvalid_q;

	// Checks
	a_tcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tcnt_q <= CW'(TAPE_DEPTH))
		else $error("fill tape count above depth");

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !(bid_we || ask_we))
		else $error("level memory written while idle");

	a_fill_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		fill |=> (rem_q < $past(rem_q)))
		else $error("fill did not reduce remaining quantity");

	a_clear_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> (clr_cnt_q != '0))
		else $error("clear run with zero count");

	a_tape_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && o_tvalid_q) |-> (o_filled_q == '0 && o_swept_q == '0))
		else $error("tape read result carries order fields");

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for price_level_order_matcher: a behavioral order
// book predicts every result word. Depends on plm_pkg and the matcher RTL.
module tb_top;
	import plm_pkg::*;

	localparam int unsigned WIN  = DEF_WINDOW_TICKS;
	localparam int unsigned TDEP = DEF_TAPE_DEPTH;
	localparam int unsigned HALF = WIN / 2;
	localparam int unsigned QTR  = WIN / 4;
	localparam longint CYCLE_LIMIT = 60000000;

	typedef struct packed {
		logic [31:0] top_bid;
		logic        top_bid_valid;
		logic [31:0] top_ask;
		logic        top_ask_valid;
		logic [31:0] filled_total;
		logic [10:0] levels_swept;
		logic [31:0] rested_qty;
		logic        remainder_lost;
		logic [31:0] tape_tick;
		logic [31:0] tape_qty;
		logic [63:0] tape_time;
		logic        tape_valid;
	} book_result_t;

	logic clk;
	logic arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic op, side;
	logic [31:0] limit_tick, quantity;
	logic [63:0] timestamp;
	logic [3:0] tape_index;
	book_result_t dut_res;

	// Predicted book state
	logic [31:0] bid_book [WIN];
	logic [31:0] ask_book [WIN];
	logic [31:0] scratch [WIN];
	logic [31:0] origin;
	logic        centred;
	logic [31:0] fill_px [TDEP];
	logic [31:0] fill_qt [TDEP];
	logic [63:0] fill_ts [TDEP];
	int unsigned fill_head, fill_cnt;

	book_result_t expected_q[$];
	int  errors;
	int  words_sent, orders_sent, reads_sent, fills_seen, lost_seen;
	bit  idle_en;
	longint cycles;

	price_level_order_matcher u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .side(side), .limit_tick(limit_tick), .quantity(quantity),
		.timestamp(timestamp), .tape_index(tape_index),
		.out_valid(out_valid), .out_ready(out_ready),
		.top_bid(dut_res.top_bid), .top_bid_valid(dut_res.top_bid_valid),
		.top_ask(dut_res.top_ask), .top_ask_valid(dut_res.top_ask_valid),
		.filled_total(dut_res.filled_total), .levels_swept(dut_res.levels_swept),
		.rested_qty(dut_res.rested_qty), .remainder_lost(dut_res.remainder_lost),
		.tape_tick(dut_res.tape_tick), .tape_qty(dut_res.tape_qty),
		.tape_time(dut_res.tape_time), .tape_valid(dut_res.tape_valid)
	);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// Best occupied offset: highest for bids, lowest for asks
	function automatic bit best_offset(input bit bids, output int unsigned o);
		for (int i = 0; i < WIN; i++) begin
			int unsigned k;
			k = bids ? WIN - 1 - i : i;
			if ((bids ? bid_book[k] : ask_book[k]) != 0) begin
				o = k;
				return 1'b1;
			end
		end
		o = 0;
		return 1'b0;
	endfunction

	function automatic bit outer_band(input int unsigned o);
		return o < QTR || o >= WIN - QTR;
	endfunction

	// Recentre on the mid when a best price sits in the outer quarter
	task automatic recentre_book();
		int unsigned bo, ao;
		bit bv, av;
		longint mid, nb, delta, src;
		bv = best_offset(1'b1, bo);
		av = best_offset(1'b0, ao);
		if (!bv && !av) return;
		if (!((bv && outer_band(bo)) || (av && outer_band(ao)))) return;
		if (bv && av) mid = (2 * longint'(origin) + bo + ao) / 2;
		else if (bv) mid = longint'(origin) + bo;
		else mid = longint'(origin) + ao;
		nb = mid >= HALF ? mid - HALF : 0;
		delta = nb - longint'(origin);
		for (int i = 0; i < WIN; i++) begin
			src = i + delta;
			scratch[i] = (src >= 0 && src < WIN) ? bid_book[src] : 32'd0;
		end
		bid_book = scratch;
		for (int i = 0; i < WIN; i++) begin
			src = i + delta;
			scratch[i] = (src >= 0 && src < WIN) ? ask_book[src] : 32'd0;
		end
		ask_book = scratch;
		origin = nb[31:0];
	endtask

	// Apply one word to the book and return the expected result word
	task automatic predict_word(input logic o_op, input logic o_side, input logic [31:0] px,
			input logic [31:0] qty, input logic [63:0] ts, input logic [3:0] idx,
			output book_result_t r);
		int unsigned off, bo, ao, k;
		logic [31:0] remaining, have, take;
		longint tick, rel;
		r = '0;
		remaining = qty;
		if (o_op == OP_ORDER) begin
			if (!centred) begin
				origin = px >= HALF ? px - HALF : 32'd0;
				centred = 1'b1;
			end
			while (remaining > 0 && best_offset(o_side == SIDE_ASK, off)) begin
				tick = longint'(origin) + off;
				have = (o_side == SIDE_ASK) ? bid_book[off] : ask_book[off];
				if (o_side == SIDE_BID ? tick > px : tick < px) break;
				take = remaining < have ? remaining : have;
				fill_px[fill_head] = tick[31:0];
				fill_qt[fill_head] = take;
				fill_ts[fill_head] = ts;
				fill_head = (fill_head + 1) % TDEP;
				if (fill_cnt < TDEP) fill_cnt++;
				if (o_side == SIDE_ASK) bid_book[off] = have - take;
				else ask_book[off] = have - take;
				remaining -= take;
				r.filled_total += take;
				if (r.levels_swept != SWEPT_MAX) r.levels_swept++;
			end
			if (remaining > 0) begin
				rel = longint'(px) - longint'(origin);
				if (rel >= 0 && rel < WIN) begin
					if (o_side == SIDE_ASK) ask_book[rel] = remaining;
					else bid_book[rel] = remaining;
					r.rested_qty = remaining;
				end else r.remainder_lost = 1'b1;
			end
			recentre_book();
		end else if (idx < fill_cnt) begin
			k = (fill_head + TDEP - 1 - idx) % TDEP;
			r.tape_tick = fill_px[k];
			r.tape_qty = fill_qt[k];
			r.tape_time = fill_ts[k];
			r.tape_valid = 1'b1;
		end
		if (best_offset(1'b1, bo)) begin
			r.top_bid = origin + bo;
			r.top_bid_valid = 1'b1;
		end
		if (best_offset(1'b0, ao)) begin
			r.top_ask = origin + ao;
			r.top_ask_valid = 1'b1;
		end
	endtask

	// Send one word; valid stays up into the next word unless the sender idles
	task automatic send_word(input logic o_op, input logic o_side, input logic [31:0] px,
			input logic [31:0] qty, input logic [63:0] ts, input logic [3:0] idx);
		book_result_t r;
		while (idle_en && $urandom_range(99) < 17) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o_op;
		side <= o_side;
		limit_tick <= px;
		quantity <= qty;
		timestamp <= ts;
		tape_index <= idx;
		do @(posedge clk); while (!in_ready);
		predict_word(o_op, o_side, px, qty, ts, idx, r);
		expected_q.push_back(r);
		words_sent++;
		if (o_op == OP_ORDER) begin
			orders_sent++;
			fills_seen += r.levels_swept;
			lost_seen += r.remainder_lost;
		end else reads_sent++;
	endtask

	task automatic order_word(input logic s, input logic [31:0] px, input logic [31:0] qty);
		send_word(OP_ORDER, s, px, qty, {$urandom, $urandom}, 4'($urandom));
	endtask

	task automatic tape_word(input logic [3:0] idx);
		send_word(OP_TAPE, 1'($urandom), $urandom, $urandom, {$urandom, $urandom}, idx);
	endtask

	// Stop sending and wait for every outstanding result
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
	endtask

	// Result checker
	always @(posedge clk) begin
		book_result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result word %h", $time, dut_res);
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (e.top_bid !== dut_res.top_bid || e.top_bid_valid !== dut_res.top_bid_valid)
					$display("%0t: top_bid exp %h/%b got %h/%b", $time, e.top_bid,
						e.top_bid_valid, dut_res.top_bid, dut_res.top_bid_valid);
				if (e.top_ask !== dut_res.top_ask || e.top_ask_valid !== dut_res.top_ask_valid)
					$display("%0t: top_ask exp %h/%b got %h/%b", $time, e.top_ask,
						e.top_ask_valid, dut_res.top_ask, dut_res.top_ask_valid);
				if (e.filled_total !== dut_res.filled_total || e.levels_swept !== dut_res.levels_swept)
					$display("%0t: fill exp %h/%0d got %h/%0d", $time, e.filled_total,
						e.levels_swept, dut_res.filled_total, dut_res.levels_swept);
				if (e.rested_qty !== dut_res.rested_qty || e.remainder_lost !== dut_res.remainder_lost)
					$display("%0t: rest exp %h/%b got %h/%b", $time, e.rested_qty,
						e.remainder_lost, dut_res.rested_qty, dut_res.remainder_lost);
				if (e.tape_tick !== dut_res.tape_tick || e.tape_qty !== dut_res.tape_qty ||
						e.tape_time !== dut_res.tape_time || e.tape_valid !== dut_res.tape_valid)
					$display("%0t: tape exp %h %h %h %b got %h %h %h %b", $time, e.tape_tick,
						e.tape_qty, e.tape_time, e.tape_valid, dut_res.tape_tick,
						dut_res.tape_qty, dut_res.tape_time, dut_res.tape_valid);
				if (e !== dut_res) errors++;
			end
		end
	end

	// Receiver stalls
	always @(posedge clk) begin
		if (!arst_n) out_ready <= 1'b0;
		else out_ready <= !idle_en || ($urandom_range(99) >= 17);
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Empty book: reads, extreme prices, zero quantity, first-order centring
	task automatic test_edges();
		tape_word(4'd0);
		tape_word(4'd15);
		order_word(SIDE_BID, 32'd100, 32'd0);
		order_word(SIDE_BID, 32'd300, 32'hFFFF_FFFF);
		order_word(SIDE_ASK, 32'd200, 32'd5);
		order_word(SIDE_ASK, 32'hFFFF_FFFF, 32'd7);
		order_word(SIDE_BID, 32'd0, 32'd9);
		tape_word(4'd0);
		tape_word(4'd1);
		tape_word(4'd15);
	endtask

	// Ladder of asks swept by one bid, then bids swept by one ask
	task automatic test_sweep();
		logic [31:0] c;
		drain();
		c = origin + HALF;
		for (int i = 1; i <= 5; i++) order_word(SIDE_ASK, c + i, 32'(i * 10));
		order_word(SIDE_BID, c + 4, 32'd1000);
		for (int i = 1; i <= 4; i++) order_word(SIDE_BID, c - i, 32'(i));
		order_word(SIDE_ASK, c - 10, 32'd3);
		for (int i = 0; i < 4; i++) tape_word(4'(i));
	endtask

	// Random orders near the current window, with tape reads and noise
	task automatic test_random(input int n);
		logic [31:0] c, px;
		for (int i = 0; i < n; i++) begin
			idle_en = !(i >= n / 3 && i < n / 3 + 100);
			c = origin + HALF;
			if ($urandom_range(9) < 2) tape_word(4'($urandom));
			else begin
				case ($urandom_range(9))
					0: px = $urandom;
					1: px = c + $urandom_range(WIN) - HALF - 64;
					default: px = c + $urandom_range(60) - 30;
				endcase
				order_word(1'($urandom), px,
					$urandom_range(3) == 0 ? $urandom : 32'($urandom_range(50)));
			end
			if (i == n / 2) drain();
		end
		idle_en = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_ORDER;
		side = SIDE_BID;
		limit_tick = '0;
		quantity = '0;
		timestamp = '0;
		tape_index = '0;
		idle_en = 1'b1;
		errors = 0;
		cycles = 0;
		words_sent = 0;
		orders_sent = 0;
		reads_sent = 0;
		fills_seen = 0;
		lost_seen = 0;
		origin = '0;
		centred = 1'b0;
		fill_head = 0;
		fill_cnt = 0;
		foreach (bid_book[i]) begin
			bid_book[i] = '0;
			ask_book[i] = '0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		test_edges();
		test_sweep();
		test_random(780);
		drain();
		repeat (4 * WIN + 100) @(posedge clk);
		$display("Sent %0d words: %0d orders, %0d tape reads; %0d fills, %0d lost remainders.",
			words_sent, orders_sent, reads_sent, fills_seen, lost_seen);
		if (errors == 0 && expected_q.size() == 0) $display("CHECK OK");
		else $display("CHECK FAILED");
		$finish;
	end
endmodule
